// File: rtl/rc4_stream_cipher_core_assert.svh
// Assertion macros for the RC4 core.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef RC4_STREAM_CIPHER_CORE_ASSERT_SVH
`define RC4_STREAM_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int KEY_LEN_W  = 9;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    // register word index on the APB port
    localparam logic REG_KEY_LENGTH = 1'b0;

    // input kind codes
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY,
        ST_EMIT,
        ST_KS0,
        ST_KS1,
        ST_KS2,
        ST_KS3,
        ST_SCLR,
        ST_SA,
        ST_SB,
        ST_SC,
        ST_SD
    } rc4_state_t;

endpackage

`default_nettype wire

// File: rtl/rc4_stream_cipher_core.sv
`default_nettype none
// RC4 stream cipher core. Key bytes (kind = 0) are stored one per request; once the
// count reaches key_length (0 acts as 1, values above MAX_KEY_BYTES are clamped) the
// standard key schedule builds the 256-byte permutation and the core is keyed. A key
// byte arriving while keyed starts a new key. Data bytes (kind = 1) come back XORed
// with the next keystream byte, the stream indices running on between bytes; a data
// byte with end_of_message set is delivered and the permutation is then rebuilt from
// the stored key, so each message starts from the same keystream. Data arriving
// before keying passes through unchanged with not_keyed set. The permutation RAM has
// two ports (one read, one write per cycle); a keyed data byte reads S[i], S[j] and
// S[S[i] + S[j]] and writes the swap, and the key schedule (and each rebuild) is a
// clear followed by one swap step per entry, four RAM accesses per swap step, with
// in_stall high meanwhile. A finished result waits in the output register, so
// a new request is taken while the previous result is still stalled. The permutation
// returns to identity via a per-entry valid bit, all cleared together; the key store has no
// reset. key_length is written over APB at byte address 0 (reset 16), pready is
// always high and reads return the register.
module rc4_stream_cipher_core #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [7:0]  byte_value,
    input  wire logic        end_of_message,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             not_keyed,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import rc4_pkg::*;

    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    rc4_state_t              state_reg, state_next;
    logic [KEY_LEN_W-1:0]    key_length_reg;
    logic [CNT_W-1:0]        key_cnt_reg, key_cnt_next;
    logic                    keyed_reg, keyed_next;
    logic [BYTE_W-1:0]       i_reg, i_next;      // stream_i
    logic [BYTE_W-1:0]       j_reg, j_next;      // stream_j
    logic [BYTE_W-1:0]       n_reg, n_next;      // schedule step
    logic [BYTE_W-1:0]       acc_reg, acc_next;  // schedule j
    logic [KIDX_W-1:0]       kidx_reg, kidx_next;
    logic                    out_valid_reg, out_valid_next;

    // payload, no reset
    logic [BYTE_W-1:0]       byte_reg, byte_next;
    logic                    eom_reg, eom_next;
    logic                    nk_reg, nk_next;
    logic [BYTE_W-1:0]       a_reg, a_next;      // S[i] / S[n] held for the swap
    logic [BYTE_W-1:0]       b_reg, b_next;      // S[j]
    logic [BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic                    last_reg, last_next;
    logic                    not_keyed_reg, not_keyed_next;

    // permutation RAM with per-entry valid bits (invalid reads as identity)
    logic [BYTE_W-1:0]       perm_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0]   perm_vld_reg;
    logic [BYTE_W-1:0]       perm_rdata_reg;
    logic                    perm_rvld_reg;
    logic [BYTE_W-1:0]       perm_raddr_reg;
    logic                    perm_we;
    logic                    perm_clr;
    logic [BYTE_W-1:0]       perm_waddr;
    logic [BYTE_W-1:0]       perm_wdata;
    logic [BYTE_W-1:0]       perm_raddr;
    logic [BYTE_W-1:0]       perm_rd;

    // key store, undefined until written
    logic [BYTE_W-1:0]       key_mem [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]       key_rdata_reg;
    logic                    key_we;
    logic [KIDX_W-1:0]       key_waddr;

    // misc
    logic [KEY_LEN_W-1:0]    eff_len;
    logic                    in_take;
    logic                    out_free;
    logic                    cfg_wr;
    logic [CNT_W-1:0]        key_base;
    logic [BYTE_W-1:0]       ks;
    logic                    sched_last;   // final swap step of a schedule
    logic                    swap_wr_st;   // states that write the permutation

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_LENGTH);
    assign prdata = (paddr[2] == REG_KEY_LENGTH) ? 32'(key_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= KEY_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            key_length_reg <= pwdata[KEY_LEN_W-1:0];
        end
    end

    // clamp to 1..MAX_KEY_BYTES
    always_comb
    begin
        if (key_length_reg == '0)
            eff_len = KEY_LEN_W'(1);
        else if (key_length_reg > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = key_length_reg;
    end

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign not_keyed = not_keyed_reg;

    // registered read; entries cleared since the last schedule read as their index
    assign perm_rd = perm_rvld_reg ? perm_rdata_reg : perm_raddr_reg;

    // keystream byte after the swap; forward the swapped values
    always_comb
    begin
        if (perm_raddr_reg == j_reg)
            ks = a_reg;
        else if (perm_raddr_reg == i_reg)
            ks = b_reg;
        else
            ks = perm_rd;
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state, datapath next values, RAM controls
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        key_cnt_next   = key_cnt_reg;
        keyed_next     = keyed_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        kidx_next      = kidx_reg;
        byte_next      = byte_reg;
        eom_next       = eom_reg;
        nk_next        = nk_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        not_keyed_next = not_keyed_reg;
        out_valid_next = out_valid_reg && out_stall;
        perm_we        = 1'b0;
        perm_clr       = 1'b0;
        perm_waddr     = i_reg;
        perm_wdata     = a_reg;
        perm_raddr     = perm_raddr_reg;
        key_we         = 1'b0;
        key_base       = keyed_reg ? '0 : key_cnt_reg;
        key_waddr      = key_base[KIDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    byte_next = byte_value;
                    eom_next  = end_of_message;
                    nk_next   = !keyed_reg;
                    if (kind == KIND_KEY)
                        state_next = ST_KEY;
                    else if (keyed_reg)
                        state_next = ST_KS0;
                    else
                        state_next = ST_EMIT;
                end
            end

            ST_KEY:
            begin
                // a key byte after keying starts a new key
                keyed_next = 1'b0;
                if (9'(key_base) < MAX_LEN)
                begin
                    key_we       = 1'b1;
                    key_cnt_next = CNT_W'(key_base + 1'b1);
                end
                else
                begin
                    key_cnt_next = key_base;
                end
                if (9'(key_cnt_next) >= eff_len)
                    state_next = ST_SCLR;
                else
                    state_next = ST_IDLE;
            end

            ST_KS0:
            begin
                i_next     = i_reg + 1'b1;
                perm_raddr = i_reg + 1'b1;
                state_next = ST_KS1;
            end

            ST_KS1:
            begin
                a_next     = perm_rd;
                j_next     = j_reg + perm_rd;
                perm_raddr = j_reg + perm_rd;
                state_next = ST_KS2;
            end

            ST_KS2:
            begin
                // S[i] <= S[j]; read S[S[i] + S[j]] from the old contents
                b_next     = perm_rd;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rd;
                perm_raddr = a_reg + perm_rd;
                state_next = ST_KS3;
            end

            ST_KS3:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = a_reg;
                byte_next  = byte_reg ^ ks;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg;
                    last_next      = eom_reg;
                    not_keyed_next = nk_reg;
                    if (eom_reg && !nk_reg)
                        state_next = ST_SCLR;
                    else
                        state_next = ST_IDLE;
                end
            end

            ST_SCLR:
            begin
                perm_clr   = 1'b1;
                i_next     = '0;
                j_next     = '0;
                n_next     = '0;
                acc_next   = '0;
                kidx_next  = '0;
                state_next = ST_SA;
            end

            ST_SA:
            begin
                // key store is read at kidx_reg every cycle
                perm_raddr = n_reg;
                state_next = ST_SB;
            end

            ST_SB:
            begin
                a_next     = perm_rd;
                acc_next   = acc_reg + key_rdata_reg + perm_rd;
                perm_raddr = acc_reg + key_rdata_reg + perm_rd;
                state_next = ST_SC;
            end

            ST_SC:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = perm_rd;
                state_next = ST_SD;
            end

            ST_SD:
            begin
                perm_we    = 1'b1;
                perm_waddr = acc_reg;
                perm_wdata = a_reg;
                n_next     = n_reg + 1'b1;
                if (9'(kidx_reg) == (eff_len - 1'b1))
                    kidx_next = '0;
                else
                    kidx_next = kidx_reg + 1'b1;
                if (n_reg == 8'hFF)
                begin
                    keyed_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SA;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cnt_reg   <= '0;
            keyed_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            perm_vld_reg  <= '0;
        end
        else
        begin
            key_cnt_reg   <= key_cnt_next;
            keyed_reg     <= keyed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
            if (perm_clr)
                perm_vld_reg <= '0;
            else if (perm_we)
                perm_vld_reg[perm_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        eom_reg       <= eom_next;
        nk_reg        <= nk_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
        not_keyed_reg <= not_keyed_next;
    end

    // ---------------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        perm_rdata_reg <= perm_mem[perm_raddr];
        perm_rvld_reg  <= perm_vld_reg[perm_raddr];
        perm_raddr_reg <= perm_raddr;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= byte_reg;
        key_rdata_reg <= key_mem[kidx_reg];
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    assign sched_last = (state_reg == ST_SD) && (n_reg == 8'hFF);
    assign swap_wr_st = (state_reg == ST_SC) || (state_reg == ST_SD) ||
                        (state_reg == ST_KS2) || (state_reg == ST_KS3);

`include "rc4_stream_cipher_core_assert.svh"

    `RC4_ASSERT_NEXT(a_sched_done, sched_last, keyed_reg && !in_stall, "bad schedule end")
    `RC4_ASSERT_IMPL(a_ks_keyed, (state_reg == ST_KS0), keyed_reg, "keystream step while unkeyed")
    `RC4_ASSERT_IMPL(a_key_cnt, 1'b1, key_cnt_reg <= CNT_W'(MAX_KEY_BYTES), "key count overflow")
    `RC4_ASSERT_IMPL(a_perm_we, perm_we, swap_wr_st, "permutation written outside a swap")

endmodule

`default_nettype wire

// File: tb/tb_rc4_stream_cipher_core.sv
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_core;

    import rc4_pkg::*;

    // Key store depth handed to the core; the predictor clamps to the same value
    localparam int          KEY_STORE_DEPTH = 256;
    // Settle time after the queue drains; covers a key schedule or rebuild with a margin
    localparam int          SETTLE_CYCLES   = 1200;
    localparam int          RANDOM_REQUESTS = 1100;
    localparam int          PHASE_REQUESTS  = 120;
    localparam int unsigned CYCLE_LIMIT     = 10_000_000;

    // key_length is register 0, so byte address 0
    localparam logic [2:0]  KEY_LENGTH_ADDR = {REG_KEY_LENGTH, 2'b00};

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       not_keyed;
    } cipher_result_t;

    typedef struct packed {
        logic           kind;
        logic [7:0]     value;
        logic           eom;
        logic           typed;      // 1: result below is the answer, else predictor
        cipher_result_t want;
    } stim_row_t;

    // Directed opening. With the reset key length of 16:
    //  - data before any key passes straight through, flagged not keyed
    //  - sixteen key bytes, one of them carrying a stray end mark
    //  - a short keyed message, then one byte of the next message, which must
    //    start from the same keystream as the first
    //  - a key byte while keyed drops the core back to unkeyed
    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{KIND_DATA, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{KIND_DATA, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{KIND_DATA, 8'h5A, 1'b0, 1'b1, '{8'h5A, 1'b0, 1'b1}},
        '{KIND_KEY,  8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h80, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h7F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'hAA, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h55, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h12, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h34, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h56, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h78, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h9A, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'hBC, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'hDE, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'hF0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h0F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_DATA, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_DATA, 8'hFF, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_DATA, 8'h3C, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_DATA, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_KEY,  8'h11, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{KIND_DATA, 8'hC3, 1'b1, 1'b1, '{8'hC3, 1'b1, 1'b1}}
    };

    // ---------------------------------------------------------------------
    // Clock, reset and DUT signals (every signal the bench drives is known from time zero)
    // ---------------------------------------------------------------------
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic        kind           = KIND_KEY;
    logic [7:0]  byte_value     = 8'h00;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        not_keyed;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    rc4_stream_cipher_core #(
        .MAX_KEY_BYTES (KEY_STORE_DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .byte_value     (byte_value),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last           (last),
        .not_keyed      (not_keyed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Cipher predictor: its own permutation, key store, indices and count
    // ---------------------------------------------------------------------
    logic [7:0]     perm_model [PERM_DEPTH];
    logic [7:0]     key_model  [KEY_STORE_DEPTH];
    logic [7:0]     idx_i;
    logic [7:0]     idx_j;
    int unsigned    key_count;
    // Key store entries 0..store_fill-1 have been written at least once
    int unsigned    store_fill;
    logic           keyed_model;
    logic [8:0]     key_length_model = KEY_LEN_RESET;

    cipher_result_t expected_bytes [$];
    int             mismatch_count = 0;
    int unsigned    cycle_count    = 0;
    int unsigned    requests_sent  = 0;
    int             send_idle_pct  = 0;
    int             recv_idle_pct  = 0;

    // 0 behaves as 1, anything above the store depth is clamped
    function automatic int unsigned effective_key_length();
        if (key_length_model == 0)
            return 1;
        if (key_length_model > KEY_STORE_DEPTH)
            return KEY_STORE_DEPTH;
        return key_length_model;
    endfunction

    // Standard key schedule from the stored key; indices back to zero
    function automatic void rebuild_permutation();
        int unsigned len;
        int          n;
        logic [7:0]  acc;
        logic [7:0]  held;
        len = effective_key_length();
        acc = 8'h00;
        for (n = 0; n < PERM_DEPTH; n++)
            perm_model[n] = n[7:0];
        for (n = 0; n < PERM_DEPTH; n++)
        begin
            acc = acc + key_model[n % len] + perm_model[n];
            held = perm_model[n];
            perm_model[n] = perm_model[acc];
            perm_model[acc] = held;
        end
        idx_i = 8'h00;
        idx_j = 8'h00;
    endfunction

    // Advances the model by one request; returns 1 when a result is due
    function automatic logic predict_cipher(input logic req_kind, input logic [7:0] req_byte,
                                            input logic req_eom, output cipher_result_t res);
        logic [7:0] si;
        logic [7:0] sj;
        logic [7:0] ks_idx;
        res = '0;
        if (req_kind == KIND_KEY)
        begin
            // a key byte while keyed starts a fresh key
            if (keyed_model)
            begin
                keyed_model = 1'b0;
                key_count = 0;
            end
            if (key_count < KEY_STORE_DEPTH)
            begin
                key_model[key_count] = req_byte;
                key_count++;
                if (key_count > store_fill)
                    store_fill = key_count;
            end
            if (key_count >= effective_key_length())
            begin
                rebuild_permutation();
                keyed_model = 1'b1;
            end
            return 1'b0;
        end
        res.last = req_eom;
        if (!keyed_model)
        begin
            res.out_byte = req_byte;
            res.not_keyed = 1'b1;
            return 1'b1;
        end
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm_model[idx_i];
        si = perm_model[idx_i];
        sj = perm_model[idx_j];
        perm_model[idx_i] = sj;
        perm_model[idx_j] = si;
        ks_idx = si + sj;
        res.out_byte = req_byte ^ perm_model[ks_idx];
        if (req_eom)
            rebuild_permutation();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------
    // Drives one request, holding it until taken, then updates the predictor.
    // An end mark that would make the core rebuild from key store entries
    // never written is dropped here; that rebuild is off limits.
    task automatic send_request(input logic req_kind, input logic [7:0] req_byte,
                                input logic req_eom, input logic typed,
                                input cipher_result_t typed_result);
        cipher_result_t res;
        logic eom;
        eom = req_eom;
        if (req_kind == KIND_DATA && keyed_model && effective_key_length() > store_fill)
            eom = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= req_kind;
        byte_value <= req_byte;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        if (predict_cipher(req_kind, req_byte, eom, res))
            expected_bytes.push_back(typed ? typed_result : res);
    endtask

    // Lets the last result out and any key schedule or rebuild run to the end
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // APB side
    // ---------------------------------------------------------------------
    // One transfer, psel left high so transfers can run back to back
    task automatic apb_transfer(input logic is_write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= KEY_LENGTH_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    // Optional write of key_length, then a read back against the model
    task automatic program_key_length(input logic do_write, input logic [8:0] value);
        logic [31:0] rdata;
        if (do_write)
        begin
            apb_transfer(1'b1, {23'd0, value}, rdata);
            key_length_model = value;
        end
        apb_transfer(1'b0, 32'd0, rdata);
        if (rdata !== {23'd0, key_length_model})
            report_mismatch("key_length read back", rdata, key_length_model);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stall and in-order comparison
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        cipher_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("result with none pending", out_byte, 0);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_byte, want.out_byte);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
                if (not_keyed !== want.not_keyed)
                    report_mismatch("not_keyed", not_keyed, want.not_keyed);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int          n;
        int unsigned phase_count;
        int unsigned phase_start;
        int unsigned msg_len;
        logic [8:0]  new_length;

        for (n = 0; n < PERM_DEPTH; n++)
            perm_model[n] = n[7:0];
        idx_i = 8'h00;
        idx_j = 8'h00;
        key_count = 0;
        store_fill = 0;
        keyed_model = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of key_length, then the directed rows
        program_key_length(1'b0, 9'd0);
        for (n = 0; n < DIRECTED_ROWS; n++)
            send_request(DIRECTED[n].kind, DIRECTED[n].value, DIRECTED[n].eom,
                         DIRECTED[n].typed, DIRECTED[n].want);

        // Random phases. Each starts idle with a new key length: extremes
        // first (1, 256, 0 acting as 1, 511 clamped), then mostly short keys.
        // Most traffic is a complete key followed by a few messages; the
        // rest is loose requests that may break a key or a message.
        phase_count = 0;
        while (phase_count < 6 || requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS)
        begin
            wait_until_quiet();
            case (phase_count)
                0:       new_length = 9'd1;
                1:       new_length = 9'd256;
                2:       new_length = 9'd0;
                3:       new_length = 9'd511;
                4:       new_length = 9'd2;
                default: new_length = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(17, 64))
                                                                  : 9'($urandom_range(1, 16));
            endcase
            program_key_length(1'b1, new_length);

            // receiver-heavy idling, then sender-heavy, then flat out
            if (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS / 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 80;
            end
            else if (requests_sent < DIRECTED_ROWS + 2 * RANDOM_REQUESTS / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            phase_start = requests_sent;
            while (requests_sent < phase_start + PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // fresh key now and then, only cheap ones once keyed
                    if (!keyed_model ||
                        ($urandom_range(0, 99) < 30 && effective_key_length() <= 16))
                    begin
                        if (keyed_model)
                            send_request(KIND_KEY, 8'($urandom_range(0, 255)),
                                         $urandom_range(0, 9) == 0, 1'b0, '0);
                        while (!keyed_model)
                            send_request(KIND_KEY, 8'($urandom_range(0, 255)),
                                         $urandom_range(0, 9) == 0, 1'b0, '0);
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        msg_len = $urandom_range(1, 12);
                        for (n = 0; n < msg_len; n++)
                            send_request(KIND_DATA, 8'($urandom_range(0, 255)),
                                         n == msg_len - 1, 1'b0, '0);
                    end
                end
                else
                begin
                    send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end

            // sometimes leave a key half done so the next length lands mid-key
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3))
                    send_request(KIND_KEY, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            phase_count++;
        end

        wait_until_quiet();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_stream_cipher_core.sv
tb/tb_rc4_stream_cipher_core.sv
